FILE: rtl/lcdn_pkg.sv
// ----------------------------------------------------------------------------
// lcdn_pkg
// Shared types and constants for the 4-bit character LCD controller.
// ----------------------------------------------------------------------------
package lcdn_pkg;

  // Duration registers are 20 bits wide
  localparam int DUR_W = 20;

  // Default wait counter width
  localparam int COUNTER_WIDTH_DEF = 20;

  // Entries in the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Register reset values, in ticks
  localparam logic [DUR_W-1:0] EN_HIGH_RST  = DUR_W'(830);
  localparam logic [DUR_W-1:0] EN_LOW_RST   = DUR_W'(830);
  localparam logic [DUR_W-1:0] POWERUP_RST  = DUR_W'(20000);
  localparam logic [DUR_W-1:0] FIRST_WT_RST = DUR_W'(5000);
  localparam logic [DUR_W-1:0] SHORT_WT_RST = DUR_W'(250);

  // Register indexes on the configuration port
  localparam logic [2:0] REG_EN_HIGH  = 3'd0;
  localparam logic [2:0] REG_EN_LOW   = 3'd1;
  localparam logic [2:0] REG_POWERUP  = 3'd2;
  localparam logic [2:0] REG_FIRST_WT = 3'd3;
  localparam logic [2:0] REG_SHORT_WT = 3'd4;

  // Power-up command bytes and nibbles
  localparam logic [7:0] CMD_FUNC_SET = 8'h28;
  localparam logic [7:0] CMD_DISP_ON  = 8'h0C;
  localparam logic [7:0] CMD_ENTRY    = 8'h06;
  localparam logic [7:0] CMD_CLEAR    = 8'h01;
  localparam logic [3:0] NIB_8BIT     = 4'h3;
  localparam logic [3:0] NIB_4BIT     = 4'h2;

  typedef enum logic [0:0] {
    ITEM_TICK  = 1'b0,
    ITEM_WRITE = 1'b1
  } item_kind_t;

  typedef struct packed {
    item_kind_t kind;
    logic       rs_select;
    logic [7:0] byte_value;
  } item_t;

  typedef struct packed {
    logic [DUR_W-1:0] en_high;
    logic [DUR_W-1:0] en_low;
    logic [DUR_W-1:0] powerup;
    logic [DUR_W-1:0] first_wait;
    logic [DUR_W-1:0] short_wait;
  } dur_cfg_t;

  typedef enum logic [4:0] {
    STEP_POWERUP   = 5'd0,
    STEP_FS1_HI    = 5'd1,
    STEP_FS1_LO    = 5'd2,
    STEP_FS1_WAIT  = 5'd3,
    STEP_FS2_HI    = 5'd4,
    STEP_FS2_LO    = 5'd5,
    STEP_FS2_WAIT  = 5'd6,
    STEP_FS3_HI    = 5'd7,
    STEP_FS3_LO    = 5'd8,
    STEP_FS3_WAIT  = 5'd9,
    STEP_MODE_HI   = 5'd10,
    STEP_MODE_LO   = 5'd11,
    STEP_MODE_WAIT = 5'd12,
    STEP_INIT0_HI  = 5'd13,
    STEP_INIT0_LO  = 5'd14,
    STEP_INIT1_HI  = 5'd15,
    STEP_INIT1_LO  = 5'd16,
    STEP_INIT2_HI  = 5'd17,
    STEP_INIT2_LO  = 5'd18,
    STEP_INIT3_HI  = 5'd19,
    STEP_INIT3_LO  = 5'd20,
    STEP_IDLE      = 5'd21,
    STEP_WR_HI     = 5'd22,
    STEP_WR_LO     = 5'd23
  } step_t;

endpackage

FILE: rtl/char_lcd_nibble_interface_ctrl.sv
// ----------------------------------------------------------------------------
// char_lcd_nibble_interface_ctrl
// Character LCD controller on a 4-bit bus: power-up sequence and byte writes.
// ----------------------------------------------------------------------------
//  port group   direction  handshake           payload
//  in_*         input      in_valid/in_ready   req_type, rs_select, byte_value
//  out_*        output     out_valid/out_ready lcd_rs, lcd_en, lcd_data,
//                                              busy_res, accepted
//  p* (APB)     config     psel/penable/pwrite paddr, pwdata, prdata
//
//  One request per clock sustained while out_ready stays high. A request
//  accepted is written into the front queue, and the back part then turns it
//  into its result in the pin registers; the sequencer step in the back part
//  is the loop that sets the rate.
//  rst_n is synchronous: the queue empties and the sequencer restarts the
//  power-up wait. A stalled out_ready holds the result; the two-entry queue
//  keeps taking requests until full.
// ----------------------------------------------------------------------------
module char_lcd_nibble_interface_ctrl #(
  parameter int COUNTER_WIDTH = lcdn_pkg::COUNTER_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_req_type,
  input  logic        in_rs_select,
  input  logic [7:0]  in_byte_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_lcd_rs,
  output logic        out_lcd_en,
  output logic [3:0]  out_lcd_data,
  output logic        out_busy_res,
  output logic        out_accepted,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import lcdn_pkg::*;

  dur_cfg_t dur_cfg;
  item_t    q_item;
  logic     q_valid;
  logic     q_pop;

  lcdn_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .dur_cfg (dur_cfg)
  );

  lcdn_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_req_type   (in_req_type),
    .in_rs_select  (in_rs_select),
    .in_byte_value (in_byte_value),
    .q_valid       (q_valid),
    .q_pop         (q_pop),
    .q_item        (q_item)
  );

  lcdn_back #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .dur_cfg      (dur_cfg),
    .q_valid      (q_valid),
    .q_pop        (q_pop),
    .q_item       (q_item),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_lcd_rs   (out_lcd_rs),
    .out_lcd_en   (out_lcd_en),
    .out_lcd_data (out_lcd_data),
    .out_busy_res (out_busy_res),
    .out_accepted (out_accepted)
  );

endmodule

FILE: rtl/lcdn_cfg.sv
// ----------------------------------------------------------------------------
// lcdn_cfg
// APB-style register file holding the five timing durations.
// ----------------------------------------------------------------------------
module lcdn_cfg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output lcdn_pkg::dur_cfg_t dur_cfg
);
  import lcdn_pkg::*;

  dur_cfg_t   regs_r;
  logic [2:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[4:2];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;
  assign dur_cfg = regs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.en_high    <= EN_HIGH_RST;
      regs_r.en_low     <= EN_LOW_RST;
      regs_r.powerup    <= POWERUP_RST;
      regs_r.first_wait <= FIRST_WT_RST;
      regs_r.short_wait <= SHORT_WT_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_EN_HIGH:  regs_r.en_high    <= pwdata[DUR_W-1:0];
        REG_EN_LOW:   regs_r.en_low     <= pwdata[DUR_W-1:0];
        REG_POWERUP:  regs_r.powerup    <= pwdata[DUR_W-1:0];
        REG_FIRST_WT: regs_r.first_wait <= pwdata[DUR_W-1:0];
        REG_SHORT_WT: regs_r.short_wait <= pwdata[DUR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_EN_HIGH:  prdata = 32'(regs_r.en_high);
      REG_EN_LOW:   prdata = 32'(regs_r.en_low);
      REG_POWERUP:  prdata = 32'(regs_r.powerup);
      REG_FIRST_WT: prdata = 32'(regs_r.first_wait);
      REG_SHORT_WT: prdata = 32'(regs_r.short_wait);
      default:      prdata = '0;
    endcase
  end

endmodule

FILE: rtl/lcdn_front.sv
// ----------------------------------------------------------------------------
// lcdn_front
// Accepts requests, tags them as tick or byte write and queues them.
// ----------------------------------------------------------------------------
module lcdn_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          in_req_type,
  input  logic          in_rs_select,
  input  logic [7:0]    in_byte_value,
  output logic          q_valid,
  input  logic          q_pop,
  output lcdn_pkg::item_t q_item
);
  import lcdn_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  item_t            entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push;
  logic             pop;
  item_t            new_item;

  assign in_ready = (count_r != CNT_FULL);
  assign push     = in_valid & in_ready;
  assign q_valid  = (count_r != '0);
  assign pop      = q_pop & q_valid;
  assign q_item   = entry_r[rd_ptr_r];

  always_comb begin
    new_item.kind       = in_req_type ? ITEM_WRITE : ITEM_TICK;
    new_item.rs_select  = in_rs_select;
    new_item.byte_value = in_byte_value;
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= new_item;
    end
  end

endmodule

FILE: rtl/lcdn_back.sv
// ----------------------------------------------------------------------------
// lcdn_back
// Power-up and nibble-transfer sequencer; its pin registers are the result.
// ----------------------------------------------------------------------------
module lcdn_back #(
  parameter int COUNTER_WIDTH = lcdn_pkg::COUNTER_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  lcdn_pkg::dur_cfg_t dur_cfg,
  input  logic               q_valid,
  output logic               q_pop,
  input  lcdn_pkg::item_t    q_item,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_lcd_rs,
  output logic               out_lcd_en,
  output logic [3:0]         out_lcd_data,
  output logic               out_busy_res,
  output logic               out_accepted
);
  import lcdn_pkg::*;

  localparam int CW = COUNTER_WIDTH;
  localparam int DW = (CW > DUR_W) ? CW : DUR_W;
  localparam logic [DW-1:0] CNT_MAX = DW'((64'(1) << CW) - 64'(1));

  step_t            step_r, step_nxt;
  logic [CW-1:0]    wait_cnt_r, wait_cnt_nxt;
  logic [7:0]       held_byte_r, held_byte_nxt;
  logic             held_sel_r, held_sel_nxt;
  logic             low_pend_r, low_pend_nxt;
  logic             pin_rs_r, pin_rs_nxt;
  logic             pin_en_r, pin_en_nxt;
  logic [3:0]       pin_nib_r, pin_nib_nxt;
  logic             accepted_r, accepted_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic             fire;
  logic [DUR_W-1:0] dur_sel;
  logic [DW-1:0]    dur_ext;
  logic [DW-1:0]    phase_len;
  logic [CW-1:0]    wait_inc;
  logic             phase_done;
  logic             start_byte;
  logic [7:0]       start_value;
  logic             start_sel;

  // Take a new item whenever the result slot is free or being emptied
  assign fire      = q_valid & (~out_valid_r | out_ready);
  assign q_pop     = fire;

  assign out_valid    = out_valid_r;
  assign out_lcd_rs   = pin_rs_r;
  assign out_lcd_en   = pin_en_r;
  assign out_lcd_data = pin_nib_r;
  assign out_busy_res = (step_r != STEP_IDLE);
  assign out_accepted = accepted_r;

  always_comb begin
    unique case (step_r) inside
      STEP_POWERUP:  dur_sel = dur_cfg.powerup;
      STEP_FS1_WAIT: dur_sel = dur_cfg.first_wait;
      STEP_FS2_WAIT, STEP_FS3_WAIT, STEP_MODE_WAIT:
        dur_sel = dur_cfg.short_wait;
      STEP_FS1_HI, STEP_FS2_HI, STEP_FS3_HI, STEP_MODE_HI, STEP_INIT0_HI,
      STEP_INIT1_HI, STEP_INIT2_HI, STEP_INIT3_HI, STEP_WR_HI:
        dur_sel = dur_cfg.en_high;
      STEP_FS1_LO, STEP_FS2_LO, STEP_FS3_LO, STEP_MODE_LO, STEP_INIT0_LO,
      STEP_INIT1_LO, STEP_INIT2_LO, STEP_INIT3_LO, STEP_WR_LO:
        dur_sel = dur_cfg.en_low;
      default: dur_sel = DUR_W'(1);
    endcase
  end

  // Zero acts as one tick; clamp to what the counter can reach
  always_comb begin
    dur_ext = DW'(dur_sel);
    if (dur_sel == '0) begin
      phase_len = DW'(1);
    end else if (dur_ext > CNT_MAX) begin
      phase_len = CNT_MAX;
    end else begin
      phase_len = dur_ext;
    end
  end

  assign wait_inc   = (wait_cnt_r == '1) ? wait_cnt_r : wait_cnt_r + CW'(1);
  assign phase_done = (DW'(wait_inc) >= phase_len);

  always_comb begin
    step_nxt      = step_r;
    wait_cnt_nxt  = wait_cnt_r;
    held_byte_nxt = held_byte_r;
    held_sel_nxt  = held_sel_r;
    low_pend_nxt  = low_pend_r;
    pin_rs_nxt    = pin_rs_r;
    pin_en_nxt    = pin_en_r;
    pin_nib_nxt   = pin_nib_r;
    accepted_nxt  = accepted_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    start_byte    = 1'b0;
    start_value   = 8'h00;
    start_sel     = 1'b0;

    if (fire) begin
      out_valid_nxt = 1'b1;
      accepted_nxt  = 1'b0;
      if (q_item.kind == ITEM_TICK) begin
        if (step_r != STEP_IDLE) begin
          if (!phase_done) begin
            wait_cnt_nxt = wait_inc;
          end else begin
            wait_cnt_nxt = '0;
            unique case (step_r) inside
              STEP_POWERUP: begin
                pin_rs_nxt  = 1'b0;
                pin_nib_nxt = NIB_8BIT;
                pin_en_nxt  = 1'b1;
                step_nxt    = STEP_FS1_HI;
              end
              STEP_FS1_HI, STEP_FS1_LO, STEP_FS2_HI, STEP_FS2_LO,
              STEP_FS3_HI, STEP_FS3_LO, STEP_MODE_HI, STEP_MODE_LO,
              STEP_INIT0_HI, STEP_INIT1_HI, STEP_INIT2_HI, STEP_INIT3_HI,
              STEP_WR_HI: begin
                pin_en_nxt = 1'b0;
                step_nxt   = step_t'(step_r + 5'd1);
              end
              STEP_FS1_WAIT, STEP_FS2_WAIT: begin
                pin_en_nxt = 1'b1;
                step_nxt   = step_t'(step_r + 5'd1);
              end
              STEP_FS3_WAIT: begin
                pin_nib_nxt = NIB_4BIT;
                pin_en_nxt  = 1'b1;
                step_nxt    = STEP_MODE_HI;
              end
              STEP_MODE_WAIT: begin
                start_byte  = 1'b1;
                start_value = CMD_FUNC_SET;
                step_nxt    = STEP_INIT0_HI;
              end
              STEP_INIT0_LO, STEP_INIT1_LO, STEP_INIT2_LO, STEP_INIT3_LO,
              STEP_WR_LO: begin
                if (low_pend_r) begin
                  // Send the low nibble with a fresh pulse
                  pin_nib_nxt  = held_byte_r[3:0];
                  pin_en_nxt   = 1'b1;
                  low_pend_nxt = 1'b0;
                  step_nxt     = step_t'(step_r - 5'd1);
                end else begin
                  case (step_r)
                    STEP_INIT0_LO: begin
                      start_byte  = 1'b1;
                      start_value = CMD_DISP_ON;
                      step_nxt    = STEP_INIT1_HI;
                    end
                    STEP_INIT1_LO: begin
                      start_byte  = 1'b1;
                      start_value = CMD_ENTRY;
                      step_nxt    = STEP_INIT2_HI;
                    end
                    STEP_INIT2_LO: begin
                      start_byte  = 1'b1;
                      start_value = CMD_CLEAR;
                      step_nxt    = STEP_INIT3_HI;
                    end
                    default: step_nxt = STEP_IDLE;
                  endcase
                end
              end
              default: step_nxt = STEP_IDLE;
            endcase
          end
        end
      end else if (step_r == STEP_IDLE) begin
        start_byte   = 1'b1;
        start_value  = q_item.byte_value;
        start_sel    = q_item.rs_select;
        step_nxt     = STEP_WR_HI;
        accepted_nxt = 1'b1;
      end

      if (start_byte) begin
        // Load the byte and raise enable with its high nibble
        held_byte_nxt = start_value;
        held_sel_nxt  = start_sel;
        pin_rs_nxt    = start_sel;
        pin_nib_nxt   = start_value[7:4];
        pin_en_nxt    = 1'b1;
        low_pend_nxt  = 1'b1;
        wait_cnt_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= STEP_POWERUP;
      wait_cnt_r  <= '0;
      held_byte_r <= '0;
      held_sel_r  <= 1'b0;
      low_pend_r  <= 1'b0;
      pin_rs_r    <= 1'b0;
      pin_en_r    <= 1'b0;
      pin_nib_r   <= '0;
      accepted_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      wait_cnt_r  <= wait_cnt_nxt;
      held_byte_r <= held_byte_nxt;
      held_sel_r  <= held_sel_nxt;
      low_pend_r  <= low_pend_nxt;
      pin_rs_r    <= pin_rs_nxt;
      pin_en_r    <= pin_en_nxt;
      pin_nib_r   <= pin_nib_nxt;
      accepted_r  <= accepted_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: test/tb_char_lcd_nibble_interface_ctrl.sv
// ----------------------------------------------------------------------------
// tb_char_lcd_nibble_interface_ctrl
// Self-checking bench for the 4-bit character LCD controller. It brings the
// display up with short timings and then runs directed byte writes. Random
// write/tick traffic follows under several timing setups. Every request's pin
// levels are predicted and compared in order against the result channel,
// with random stalls on both sides and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_char_lcd_nibble_interface_ctrl;
  timeunit 1ns;
  timeprecision 1ps;

  import lcdn_pkg::*;

  localparam int CNT_W = COUNTER_WIDTH_DEF;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef struct packed {
    logic       rs;
    logic       en;
    logic [3:0] data;
    logic       busy;
    logic       acc;
  } lcd_pins_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_req_type = 1'b0;
  logic        in_rs_select = 1'b0;
  logic [7:0]  in_byte_value = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_lcd_rs;
  logic        out_lcd_en;
  logic [3:0]  out_lcd_data;
  logic        out_busy_res;
  logic        out_accepted;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = 5'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  char_lcd_nibble_interface_ctrl uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_req_type(in_req_type), .in_rs_select(in_rs_select),
    .in_byte_value(in_byte_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_lcd_rs(out_lcd_rs), .out_lcd_en(out_lcd_en), .out_lcd_data(out_lcd_data),
    .out_busy_res(out_busy_res), .out_accepted(out_accepted),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #4_800_000;
    $display("tb_char_lcd_nibble_interface_ctrl failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Sequencer prediction
  // --------------------------------------------------------------------------
  dur_cfg_t         dur_cfg;
  step_t            seq_step;
  logic [CNT_W-1:0] tick_cnt;
  logic [7:0]       held_byte;
  logic             held_rs;
  logic             low_pending;
  logic             pin_rs;
  logic             pin_en;
  logic [3:0]       pin_nib;

  function automatic void lcd_model_reset();
    dur_cfg.en_high    = EN_HIGH_RST;
    dur_cfg.en_low     = EN_LOW_RST;
    dur_cfg.powerup    = POWERUP_RST;
    dur_cfg.first_wait = FIRST_WT_RST;
    dur_cfg.short_wait = SHORT_WT_RST;
    seq_step    = STEP_POWERUP;
    tick_cnt    = '0;
    held_byte   = 8'h00;
    held_rs     = 1'b0;
    low_pending = 1'b0;
    pin_rs      = 1'b0;
    pin_en      = 1'b0;
    pin_nib     = 4'h0;
  endfunction

  function automatic logic [CNT_W-1:0] phase_ticks(step_t s);
    logic [31:0] d;
    case (s)
      STEP_POWERUP: d = 32'(dur_cfg.powerup);
      STEP_FS1_WAIT: d = 32'(dur_cfg.first_wait);
      STEP_FS2_WAIT, STEP_FS3_WAIT, STEP_MODE_WAIT: d = 32'(dur_cfg.short_wait);
      STEP_FS1_HI, STEP_FS2_HI, STEP_FS3_HI, STEP_MODE_HI, STEP_WR_HI,
      STEP_INIT0_HI, STEP_INIT1_HI, STEP_INIT2_HI, STEP_INIT3_HI:
        d = 32'(dur_cfg.en_high);
      STEP_FS1_LO, STEP_FS2_LO, STEP_FS3_LO, STEP_MODE_LO, STEP_WR_LO,
      STEP_INIT0_LO, STEP_INIT1_LO, STEP_INIT2_LO, STEP_INIT3_LO:
        d = 32'(dur_cfg.en_low);
      default: d = 32'd1;
    endcase
    // a zero duration still takes one tick; clamp to what the counter holds
    if (d == 0) d = 32'd1;
    if (d > 32'(CNT_MAX)) d = 32'(CNT_MAX);
    return d[CNT_W-1:0];
  endfunction

  function automatic void load_byte(logic [7:0] b, logic rs);
    held_byte   = b;
    held_rs     = rs;
    pin_rs      = rs;
    pin_nib     = b[7:4];
    pin_en      = 1'b1;
    low_pending = 1'b1;
    tick_cnt    = '0;
  endfunction

  function automatic void seq_advance();
    tick_cnt = '0;
    case (seq_step)
      STEP_POWERUP: begin
        pin_rs   = 1'b0;
        pin_nib  = NIB_8BIT;
        pin_en   = 1'b1;
        seq_step = STEP_FS1_HI;
      end
      STEP_FS1_HI, STEP_FS1_LO, STEP_FS2_HI, STEP_FS2_LO, STEP_FS3_HI, STEP_FS3_LO,
      STEP_MODE_HI, STEP_MODE_LO, STEP_INIT0_HI, STEP_INIT1_HI, STEP_INIT2_HI,
      STEP_INIT3_HI, STEP_WR_HI: begin
        pin_en   = 1'b0;
        seq_step = step_t'(seq_step + 5'd1);
      end
      STEP_FS1_WAIT, STEP_FS2_WAIT, STEP_FS3_WAIT: begin
        // the third function-set wait switches the bus over to 4-bit mode
        if (seq_step == STEP_FS3_WAIT) pin_nib = NIB_4BIT;
        pin_en   = 1'b1;
        seq_step = step_t'(seq_step + 5'd1);
      end
      STEP_MODE_WAIT: begin
        load_byte(CMD_FUNC_SET, 1'b0);
        seq_step = STEP_INIT0_HI;
      end
      STEP_INIT0_LO, STEP_INIT1_LO, STEP_INIT2_LO, STEP_INIT3_LO, STEP_WR_LO: begin
        if (low_pending) begin
          pin_nib     = held_byte[3:0];
          pin_en      = 1'b1;
          low_pending = 1'b0;
          seq_step    = step_t'(seq_step - 5'd1);
        end else begin
          case (seq_step)
            STEP_INIT0_LO: begin
              load_byte(CMD_DISP_ON, 1'b0);
              seq_step = STEP_INIT1_HI;
            end
            STEP_INIT1_LO: begin
              load_byte(CMD_ENTRY, 1'b0);
              seq_step = STEP_INIT2_HI;
            end
            STEP_INIT2_LO: begin
              load_byte(CMD_CLEAR, 1'b0);
              seq_step = STEP_INIT3_HI;
            end
            default: seq_step = STEP_IDLE;
          endcase
        end
      end
      default: seq_step = STEP_IDLE;
    endcase
  endfunction

  function automatic lcd_pins_t lcd_seq_step(item_t it);
    lcd_pins_t r;
    logic      took;
    took = 1'b0;
    if (it.kind == ITEM_TICK) begin
      if (seq_step != STEP_IDLE) begin
        if (tick_cnt != CNT_MAX) tick_cnt = tick_cnt + CNT_W'(1);
        if (tick_cnt >= phase_ticks(seq_step)) seq_advance();
      end
    end else if (seq_step == STEP_IDLE) begin
      load_byte(it.byte_value, it.rs_select);
      seq_step = STEP_WR_HI;
      took     = 1'b1;
    end
    r.rs   = pin_rs;
    r.en   = pin_en;
    r.data = pin_nib;
    r.busy = (seq_step != STEP_IDLE);
    r.acc  = took;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Request driver, result monitor, receiver stalls
  // --------------------------------------------------------------------------
  item_t     req_q[$];
  lcd_pins_t pins_q[$];
  bit        req_taken = 1'b0;
  int        send_gap = 0;
  int        stall_left = 0;
  bit        long_hold_done = 1'b0;
  int        n_taken = 0;
  int        n_results = 0;
  int        n_writes_ok = 0;
  int        n_writes_refused = 0;
  int        n_bad = 0;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !req_taken) begin
      // hold the offered request until it is taken
    end else begin
      item_t nxt;
      req_taken = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (req_q.size() > 0) begin
        nxt = req_q.pop_front();
        in_req_type   <= nxt.kind;
        in_rs_select  <= nxt.rs_select;
        in_byte_value <= nxt.byte_value;
        in_valid      <= 1'b1;
        send_gap = gap_len();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    int g;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (!long_hold_done && n_results >= 300) begin
      // long hold-off so the block backs up and drops in_ready
      long_hold_done = 1'b1;
      stall_left = 80;
      out_ready <= 1'b0;
    end else begin
      g = gap_len();
      if (g == 0) begin
        out_ready <= 1'b1;
      end else begin
        stall_left = g - 1;
        out_ready <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    lcd_pins_t want;
    lcd_pins_t got;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got = '{out_lcd_rs, out_lcd_en, out_lcd_data, out_busy_res, out_accepted};
        n_results++;
        if (pins_q.size() == 0) begin
          n_bad++;
          if (n_bad <= 10)
            $display("result %0d arrived with nothing expected: rs=%b en=%b data=%h busy=%b acc=%b",
                     n_results, got.rs, got.en, got.data, got.busy, got.acc);
        end else begin
          want = pins_q.pop_front();
          if (want.acc) n_writes_ok++;
          if (got != want) begin
            n_bad++;
            if (n_bad <= 10)
              $display("result %0d mismatch: want rs=%b en=%b data=%h busy=%b acc=%b, %s",
                       n_results, want.rs, want.en, want.data, want.busy, want.acc,
                       $sformatf("got rs=%b en=%b data=%h busy=%b acc=%b",
                                 got.rs, got.en, got.data, got.busy, got.acc));
          end
        end
      end
      if (in_valid && in_ready) begin
        if (in_req_type == ITEM_WRITE && seq_step != STEP_IDLE) n_writes_refused++;
        pins_q.push_back(lcd_seq_step(
          item_t'{item_kind_t'(in_req_type), in_rs_select, in_byte_value}));
        req_taken = 1'b1;
        n_taken++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  function automatic void push_tick();
    req_q.push_back(item_t'{ITEM_TICK, 1'($urandom), 8'($urandom)});
  endfunction

  function automatic void push_write(logic rs, logic [7:0] b);
    req_q.push_back(item_t'{ITEM_WRITE, rs, b});
  endfunction

  function automatic int eff_ticks(logic [DUR_W-1:0] v);
    return (v == 0) ? 1 : int'(v);
  endfunction

  task automatic set_timing(input logic [2:0] idx, input logic [DUR_W-1:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {12'($urandom), val};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_EN_HIGH:  dur_cfg.en_high    = val;
      REG_EN_LOW:   dur_cfg.en_low     = val;
      REG_POWERUP:  dur_cfg.powerup    = val;
      REG_FIRST_WT: dur_cfg.first_wait = val;
      REG_SHORT_WT: dur_cfg.short_wait = val;
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic load_timing(input logic [DUR_W-1:0] eh, input logic [DUR_W-1:0] el,
                             input logic [DUR_W-1:0] pu, input logic [DUR_W-1:0] fw,
                             input logic [DUR_W-1:0] sw);
    set_timing(REG_EN_HIGH, eh);
    set_timing(REG_EN_LOW, el);
    set_timing(REG_POWERUP, pu);
    set_timing(REG_FIRST_WT, fw);
    set_timing(REG_SHORT_WT, sw);
  endtask

  task automatic wait_drained();
    while (req_q.size() != 0 || in_valid || pins_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Mostly whole byte transfers (write, then just enough ticks), now and then
  // a refused write mid-transfer, plus short bursts of arbitrary requests.
  task automatic random_traffic(input int n_items);
    int sent;
    int frame;
    int extra;
    int pos;
    sent = 0;
    while (sent < n_items) begin
      frame = 2 * (eff_ticks(dur_cfg.en_high) + eff_ticks(dur_cfg.en_low));
      if ($urandom_range(0, 99) < 80) begin
        push_write(1'($urandom), 8'($urandom));
        pos = ($urandom_range(0, 99) < 15) ? $urandom_range(0, frame - 2) : -1;
        for (int i = 0; i < frame; i++) begin
          if (i == pos) push_write(1'($urandom), 8'($urandom));
          push_tick();
        end
        extra = $urandom_range(0, 2);
        repeat (extra) push_tick();
        sent += 1 + frame + extra + ((pos >= 0) ? 1 : 0);
      end else begin
        extra = $urandom_range(1, 6);
        repeat (extra) begin
          if ($urandom_range(0, 1)) push_tick();
          else push_write(1'($urandom), 8'($urandom));
        end
        // drain whatever the burst started
        repeat (frame) push_tick();
        sent += extra + frame;
      end
    end
  endtask

  initial begin
    lcd_model_reset();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // short power-up timings; a zero first wait counts as one tick
    load_timing(20'd2, 20'd1, 20'd4, 20'd0, 20'd3);

    // power-up sequence, with writes refused while it runs
    push_write(1'b1, 8'hC3);
    for (int i = 0; i < 50; i++) begin
      if (i == 20) push_write(1'b0, 8'h5A);
      push_tick();
    end

    // directed writes: each byte takes six ticks at these timings
    push_tick();
    push_write(1'b1, 8'hFF);
    push_write(1'b0, 8'h00);
    repeat (6) push_tick();
    push_write(1'b0, 8'h00);
    repeat (6) push_tick();
    push_write(1'b1, 8'hA5);
    repeat (5) push_tick();
    push_write(1'b0, 8'h3C);
    push_tick();
    wait_drained();

    // zero pulse widths; power-up waits at full scale (no longer used)
    load_timing(20'd0, 20'd0, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
    random_traffic(150);
    wait_drained();

    load_timing(20'd1, 20'd1, 20'd0, 20'd1, 20'd0);
    random_traffic(150);
    wait_drained();

    load_timing(20'($urandom_range(2, 6)), 20'($urandom_range(2, 6)), 20'($urandom),
                20'($urandom), 20'($urandom));
    random_traffic(150);
    wait_drained();

    load_timing(20'd19, 20'd11, 20'd1, 20'd1, 20'd1);
    random_traffic(150);
    wait_drained();

    repeat (10) @(posedge clk);
    $display("run covered %0d requests: power-up, %0d bytes written, %0d writes refused",
             n_taken, n_writes_ok, n_writes_refused);
    $display("five timing setups including zero and full-scale durations, %0d mismatches",
             n_bad);
    if (n_bad == 0 && pins_q.size() == 0) begin
      $display("tb_char_lcd_nibble_interface_ctrl passed");
    end else begin
      $display("tb_char_lcd_nibble_interface_ctrl failed");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/lcdn_pkg.sv
rtl/lcdn_cfg.sv
rtl/lcdn_front.sv
rtl/lcdn_back.sv
rtl/char_lcd_nibble_interface_ctrl.sv
test/tb_char_lcd_nibble_interface_ctrl.sv
